@@ rtl/cdt_pkg.sv @@
// Package with types, codes and constants of the countdown timer core.
package cdt_pkg;

  localparam int TIME_WIDTH  = 20;
  localparam int STEP_WIDTH  = 12;
  localparam int PHASE_WIDTH = 4;
  localparam int CFG_IDX_WIDTH = 2;

  localparam logic [TIME_WIDTH-1:0]  TIME_MAX          = {TIME_WIDTH{1'b1}};
  localparam logic [STEP_WIDTH-1:0]  TIME_STEP_RESET   = STEP_WIDTH'(60);
  localparam logic [PHASE_WIDTH-1:0] BEEP_PHASE_RESET  = PHASE_WIDTH'(5);
  localparam logic [PHASE_WIDTH-1:0] COUNT_PHASE_RESET = PHASE_WIDTH'(10);

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_SET   = 3'd1,
    MODE_COUNT = 3'd2,
    MODE_PAUSE = 3'd3,
    MODE_STAT  = 3'd4
  } mode_t;

  localparam logic [2:0] ACT_INC   = 3'd0;
  localparam logic [2:0] ACT_DEC   = 3'd1;
  localparam logic [2:0] ACT_TICK  = 3'd2;
  localparam logic [2:0] ACT_START = 3'd3;
  localparam logic [2:0] ACT_ABORT = 3'd4;

  localparam logic [1:0] ST_HANDLED = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_TRANS   = 2'd2;

  localparam logic [1:0] MSG_NONE   = 2'd0;
  localparam logic [1:0] MSG_SET    = 2'd1;
  localparam logic [1:0] MSG_PAUSED = 2'd2;
  localparam logic [1:0] MSG_PROD   = 2'd3;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TIME_STEP   = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_BEEP_PHASE  = CFG_IDX_WIDTH'(1);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_COUNT_PHASE = CFG_IDX_WIDTH'(2);

  typedef struct packed {
    logic [2:0]             action;
    logic [PHASE_WIDTH-1:0] sub_tick;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [2:0]            mode_now;
    logic                  show_time;
    logic [TIME_WIDTH-1:0] time_shown;
    logic [1:0]            message;
    logic                  clear_display;
    logic                  beep;
  } out_item_t;

endpackage

@@ rtl/countdown_timer_state_machine_core.sv @@
// Countdown timer core: mode state machine, time counters and result buffer.
// An accepted result is registered in out_r, or in skid_r while out_r waits.
// Throughput: one transaction per cycle unless the skid entry is full; mode and
// counters update in one combinational pass between state and result registers.
// A two-entry result buffer keeps accepting while one result waits downstream.
// Reset (synchronous, rst_n low): idle mode, counters zero, registers at defaults.
module countdown_timer_state_machine_core
  import cdt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [STEP_WIDTH-1:0]    cfg_wdata
);

  logic [STEP_WIDTH-1:0]  time_step_r;
  logic [PHASE_WIDTH-1:0] beep_phase_r;
  logic [PHASE_WIDTH-1:0] count_phase_r;

  mode_t                 mode_r, mode_nxt;
  logic [TIME_WIDTH-1:0] rem_r, rem_nxt;
  logic [TIME_WIDTH-1:0] ela_r, ela_nxt;
  logic [TIME_WIDTH-1:0] prod_r, prod_nxt;
  logic [1:0]            status_nxt;

  out_item_t res_nxt;
  out_item_t out_r, out_nxt;
  out_item_t skid_r, skid_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;

  logic                  accept;
  logic                  out_pop;
  logic [TIME_WIDTH-1:0] step_ext;
  logic [TIME_WIDTH:0]   rem_sum;
  logic [TIME_WIDTH-1:0] rem_add;
  logic [TIME_WIDTH-1:0] rem_sub;
  logic [TIME_WIDTH-1:0] rem_m1;
  logic [TIME_WIDTH:0]   ela_sum;
  logic [TIME_WIDTH-1:0] ela_inc;
  logic [TIME_WIDTH:0]   prod_sum;
  logic                  rem_ge_step;
  logic                  rem_le_one;
  logic                  is_beep_tick;
  logic                  is_count_tick;

  assign accept    = in_valid && in_ready;
  assign out_pop   = out_valid_r && out_ready;
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign step_ext      = TIME_WIDTH'(time_step_r);
  assign rem_sum       = {1'b0, rem_r} + {1'b0, step_ext};
  assign rem_add       = rem_sum[TIME_WIDTH] ? TIME_MAX : rem_sum[TIME_WIDTH-1:0];
  assign rem_ge_step   = rem_r >= step_ext;
  assign rem_sub       = rem_ge_step ? rem_r - step_ext : rem_r;
  assign rem_le_one    = (rem_r[TIME_WIDTH-1:1] == '0);
  assign rem_m1        = (rem_r == '0) ? rem_r : rem_r - TIME_WIDTH'(1);
  assign ela_sum       = {1'b0, ela_r} + (TIME_WIDTH+1)'(1);
  assign ela_inc       = ela_sum[TIME_WIDTH] ? TIME_MAX : ela_sum[TIME_WIDTH-1:0];
  assign is_beep_tick  = (in_data.action == ACT_TICK) && (in_data.sub_tick == beep_phase_r);
  assign is_count_tick = (in_data.action == ACT_TICK) && (in_data.sub_tick == count_phase_r);

  always_comb begin
    mode_nxt   = mode_r;
    status_nxt = ST_IGNORED;
    unique case (mode_r)
      MODE_IDLE: begin
        priority if (in_data.action == ACT_INC) begin
          mode_nxt   = MODE_SET;
          status_nxt = ST_TRANS;
        end else if (in_data.action == ACT_START) begin
          mode_nxt   = MODE_STAT;
          status_nxt = ST_TRANS;
        end else if (is_beep_tick) begin
          status_nxt = ST_HANDLED;
        end else begin
          status_nxt = ST_IGNORED;
        end
      end
      MODE_SET: begin
        priority if (in_data.action == ACT_INC || in_data.action == ACT_DEC) begin
          status_nxt = ST_TRANS;
        end else if (in_data.action == ACT_START) begin
          if (rem_ge_step) begin
            mode_nxt = MODE_COUNT;
          end
          status_nxt = ST_TRANS;
        end else if (in_data.action == ACT_ABORT) begin
          mode_nxt   = MODE_IDLE;
          status_nxt = ST_TRANS;
        end else begin
          status_nxt = ST_IGNORED;
        end
      end
      MODE_COUNT: begin
        priority if (in_data.action == ACT_START) begin
          mode_nxt   = MODE_PAUSE;
          status_nxt = ST_TRANS;
        end else if (is_count_tick) begin
          if (rem_le_one) begin
            mode_nxt   = MODE_IDLE;
            status_nxt = ST_TRANS;
          end else begin
            status_nxt = ST_HANDLED;
          end
        end else begin
          status_nxt = ST_IGNORED;
        end
      end
      MODE_PAUSE: begin
        priority if (in_data.action == ACT_INC || in_data.action == ACT_DEC) begin
          mode_nxt   = MODE_SET;
          status_nxt = ST_TRANS;
        end else if (in_data.action == ACT_START) begin
          mode_nxt   = MODE_COUNT;
          status_nxt = ST_TRANS;
        end else begin
          status_nxt = ST_IGNORED;
        end
      end
      MODE_STAT: begin
        if (is_count_tick) begin
          mode_nxt   = MODE_IDLE;
          status_nxt = ST_TRANS;
        end
      end
      default: begin
        mode_nxt   = mode_r;
        status_nxt = ST_IGNORED;
      end
    endcase
  end

  always_comb begin
    rem_nxt  = rem_r;
    ela_nxt  = ela_r;
    prod_nxt = prod_r;
    prod_sum = '0;
    res_nxt  = '0;

    unique case (mode_r)
      MODE_IDLE: begin
        if (in_data.action == ACT_INC) begin
          rem_nxt = rem_add;
        end
        res_nxt.beep = (status_nxt == ST_HANDLED);
      end
      MODE_SET: begin
        priority if (in_data.action == ACT_INC) begin
          rem_nxt            = rem_add;
          res_nxt.show_time  = 1'b1;
          res_nxt.time_shown = rem_add;
        end else if (in_data.action == ACT_DEC) begin
          rem_nxt            = rem_sub;
          res_nxt.show_time  = 1'b1;
          res_nxt.time_shown = rem_sub;
        end else begin
          rem_nxt = rem_r;
        end
      end
      MODE_COUNT: begin
        if (in_data.action != ACT_START && is_count_tick) begin
          rem_nxt            = rem_m1;
          ela_nxt            = ela_inc;
          res_nxt.show_time  = 1'b1;
          res_nxt.time_shown = rem_m1;
        end
      end
      MODE_PAUSE: begin
        priority if (in_data.action == ACT_INC) begin
          rem_nxt = rem_add;
        end else if (in_data.action == ACT_DEC) begin
          rem_nxt = rem_sub;
        end else begin
          rem_nxt = rem_r;
        end
      end
      default: begin
        rem_nxt = rem_r;
      end
    endcase

    if (status_nxt == ST_TRANS) begin
      if (mode_r == MODE_COUNT) begin
        prod_sum = {1'b0, prod_r} + {1'b0, ela_nxt};
        prod_nxt = prod_sum[TIME_WIDTH] ? TIME_MAX : prod_sum[TIME_WIDTH-1:0];
        ela_nxt  = '0;
      end else begin
        res_nxt.clear_display = 1'b1;
      end
      unique case (mode_nxt)
        MODE_IDLE: begin
          rem_nxt            = '0;
          ela_nxt            = '0;
          res_nxt.show_time  = 1'b1;
          res_nxt.time_shown = '0;
          res_nxt.message    = MSG_SET;
        end
        MODE_SET: begin
          res_nxt.show_time  = 1'b1;
          res_nxt.time_shown = rem_nxt;
        end
        MODE_PAUSE: begin
          res_nxt.message = MSG_PAUSED;
        end
        MODE_STAT: begin
          res_nxt.show_time  = 1'b1;
          res_nxt.time_shown = prod_nxt;
          res_nxt.message    = MSG_PROD;
        end
        default: begin
          res_nxt.message = MSG_NONE;
        end
      endcase
    end

    res_nxt.status   = status_nxt;
    res_nxt.mode_now = mode_nxt;
  end

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    priority if (skid_valid_r) begin
      if (out_pop) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || out_pop) begin
        out_nxt       = res_nxt;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res_nxt;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r   <= TIME_STEP_RESET;
      beep_phase_r  <= BEEP_PHASE_RESET;
      count_phase_r <= COUNT_PHASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIME_STEP:   time_step_r   <= cfg_wdata;
        CFG_BEEP_PHASE:  beep_phase_r  <= cfg_wdata[PHASE_WIDTH-1:0];
        CFG_COUNT_PHASE: count_phase_r <= cfg_wdata[PHASE_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      rem_r        <= '0;
      ela_r        <= '0;
      prod_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r <= mode_nxt;
        rem_r  <= rem_nxt;
        ela_r  <= ela_nxt;
        prod_r <= prod_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a pending result");

  a_time_zero_when_hidden: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.show_time) |-> (out_r.time_shown == '0))
    else $error("time value present without display request");

  a_clear_on_transition: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.clear_display) |-> (out_r.status == ST_TRANS))
    else $error("display cleared without a transition");

  a_ignored_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && status_nxt == ST_IGNORED) |=>
      (mode_r == $past(mode_r) && rem_r == $past(rem_r) && prod_r == $past(prod_r)))
    else $error("ignored transaction changed state");

  a_count_exit_clears_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode_r == MODE_COUNT && status_nxt == ST_TRANS) |=> (ela_r == '0))
    else $error("elapsed time kept after leaving countdown");

endmodule
